### hw/rtl/sorted_region_table_overlap_macros.svh
// Assertion macros for the sorted region table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SORTED_REGION_TABLE_OVERLAP_MACROS_SVH
`define SORTED_REGION_TABLE_OVERLAP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/srto_pkg.sv
// Package for the sorted region table: sizes, request codes, FSM states
// and the control/status structs between the top level and the cell row.
package srto_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = 48;
  localparam int SUM_W       = ADDR_W + 1;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int MIDX_W      = 4;
  localparam int MCNT_W      = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_USER_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_SPAN = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic do_insert;
    logic do_query;
  } chain_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
  } chain_stat_t;

endpackage

### hw/rtl/sorted_region_table_overlap.sv
// Sorted address-range table with overlap lookup and user-window check.
// Top level; depends on srto_pkg, srto_chain, srto_cell and the macro header.
//
// Holds up to MAX_ENTRIES (16) ranges in ascending start order, one per cell
// of a cell row. Each request passes an execute and a response state: in the
// first the whole row compares against the request range at once (an insert
// shifts the upper cells up by one and drops the new range in place, a query
// latches one hit bit per cell, a check tests the user window), in the second
// the first hit is encoded and the result is registered. A new request can be
// taken in the response state while the result side keeps up; a waiting result
// keeps the finished request there and the next one at the input until taken.
// The table needs no clearing after reset: slot occupancy follows the entry
// count alone. Config writes (user_base, user_span) are taken every cycle and
// act at once; they are meant to be issued only while the block is idle.
`include "sorted_region_table_overlap_macros.svh"

module sorted_region_table_overlap (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [srto_pkg::KIND_W-1:0]    in_kind,
  input  logic [srto_pkg::ADDR_W-1:0]    in_seg_start,
  input  logic [srto_pkg::ADDR_W-1:0]    in_seg_length,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_success,
  output logic [srto_pkg::MIDX_W-1:0]    out_match_index,
  output logic [srto_pkg::ADDR_W-1:0]    out_match_start,
  output logic [srto_pkg::ADDR_W-1:0]    out_match_length,
  output logic [srto_pkg::MCNT_W-1:0]    out_entry_count,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srto_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srto_pkg::ADDR_W-1:0]    cfg_data
);
  import srto_pkg::*;

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [ADDR_W-1:0] seg_start_r, seg_start_nxt;
  logic [ADDR_W-1:0] seg_length_r, seg_length_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ok_r, ok_nxt;
  logic [ADDR_W-1:0] user_base_r, user_base_nxt;
  logic [ADDR_W-1:0] user_span_r, user_span_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_success_r, out_success_nxt;
  logic [MIDX_W-1:0] out_index_r, out_index_nxt;
  logic [ADDR_W-1:0] out_start_r, out_start_nxt;
  logic [ADDR_W-1:0] out_length_r, out_length_nxt;
  logic [MCNT_W-1:0] out_count_r, out_count_nxt;

  chain_ctrl_t       ctrl;
  chain_stat_t       stat;
  logic              slot_free;
  logic              in_acc;
  logic [SUM_W-1:0]  seg_end;
  logic [SUM_W-1:0]  win_end;
  logic              in_window;

  assign cfg_ready = 1'b1;

  // result slot can take a new result this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_RESP) && slot_free);
  assign in_acc    = in_valid && in_ready;

  // user window test, no wrap: sums at 49 bits
  assign seg_end   = {1'b0, seg_start_r} + {1'b0, seg_length_r};
  assign win_end   = {1'b0, user_base_r} + {1'b0, user_span_r};
  assign in_window = (seg_start_r >= user_base_r) && (seg_end <= win_end);

  srto_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .count      (count_r),
    .seg_start  (seg_start_r),
    .seg_length (seg_length_r),
    .stat       (stat)
  );

  // config decode
  always_comb begin
    user_base_nxt = user_base_r;
    user_span_nxt = user_span_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_USER_BASE: user_base_nxt = cfg_data;
        CFG_USER_SPAN: user_span_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    seg_start_nxt   = seg_start_r;
    seg_length_nxt  = seg_length_r;
    count_nxt       = count_r;
    ok_nxt          = ok_r;
    ctrl            = '0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_success_nxt = out_success_r;
    out_index_nxt   = out_index_r;
    out_start_nxt   = out_start_r;
    out_length_nxt  = out_length_r;
    out_count_nxt   = out_count_r;

    if (in_acc) begin
      kind_nxt       = in_kind;
      seg_start_nxt  = in_seg_start;
      seg_length_nxt = in_seg_length;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_nxt    = 1'b0;
        state_nxt = ST_RESP;
        unique case (kind_r)
          KIND_INSERT: begin
            if (count_r < CNT_MAX) begin
              ctrl.do_insert = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              ok_nxt         = 1'b1;
            end
          end
          KIND_FIND:  ctrl.do_query = 1'b1;
          KIND_CHECK: ok_nxt        = in_window;
          default: ;
        endcase
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_success_nxt = ok_r;
          out_index_nxt   = '0;
          out_start_nxt   = '0;
          out_length_nxt  = '0;
          out_count_nxt   = MCNT_W'(count_r);
          if (kind_r == KIND_FIND) begin
            out_success_nxt = stat.found;
            if (stat.found) begin
              out_index_nxt  = MIDX_W'(stat.idx);
              out_start_nxt  = stat.start;
              out_length_nxt = stat.length;
            end
          end
          state_nxt = in_acc ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      user_base_r <= '0;
      user_span_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      user_base_r <= user_base_nxt;
      user_span_r <= user_span_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    seg_start_r   <= seg_start_nxt;
    seg_length_r  <= seg_length_nxt;
    ok_r          <= ok_nxt;
    out_success_r <= out_success_nxt;
    out_index_r   <= out_index_nxt;
    out_start_r   <= out_start_nxt;
    out_length_r  <= out_length_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_success      = out_success_r;
  assign out_match_index  = out_index_r;
  assign out_match_start  = out_start_r;
  assign out_match_length = out_length_r;
  assign out_entry_count  = out_count_r;

  // checks
  `SRTO_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CNT_MAX, "entry count above capacity")
  `SRTO_ASSERT_NEXT(a_insert_grows, (state_r == ST_EXEC) && ctrl.do_insert, count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `SRTO_ASSERT_NEXT(a_other_keeps, (state_r == ST_EXEC) && !ctrl.do_insert, $stable(count_r), "count moved without insert")
  `SRTO_ASSERT_NOW(a_hit_in_use, (state_r == ST_RESP) && (kind_r == KIND_FIND) && stat.found, CNT_W'(stat.idx) < count_r, "hit on empty slot")
  `SRTO_ASSERT_NOW(a_no_accept_exec, state_r == ST_EXEC, !in_ready, "request taken during compare cycle")

endmodule

### hw/rtl/srto_cell.sv
// One table slot: holds a range, compares it against the request range and
// shifts in from its lower neighbor on insert. Depends on srto_pkg.
module srto_cell (
  input  logic                      clk,
  input  logic                      ins_en,
  input  logic                      occ,
  input  logic [srto_pkg::ADDR_W-1:0] seg_start,
  input  logic [srto_pkg::ADDR_W-1:0] seg_length,
  input  logic [srto_pkg::SUM_W-1:0]  seg_end,
  input  logic                      prev_after,
  input  logic [srto_pkg::ADDR_W-1:0] prev_start,
  input  logic [srto_pkg::ADDR_W-1:0] prev_length,
  output logic                      after,
  output logic                      hit,
  output logic [srto_pkg::ADDR_W-1:0] cur_start,
  output logic [srto_pkg::ADDR_W-1:0] cur_length
);
  import srto_pkg::*;

  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] length_r, length_nxt;
  logic [SUM_W-1:0]  cell_end;

  assign cell_end = {1'b0, start_r} + {1'b0, length_r};

  // at or past the insert position: empty slot or a strictly larger start
  assign after = !occ || (start_r > seg_start);

  assign hit = occ && ({1'b0, start_r} < seg_end) && ({1'b0, seg_start} < cell_end);

  always_comb begin
    start_nxt  = start_r;
    length_nxt = length_r;
    if (ins_en) begin
      if (after && !prev_after) begin
        start_nxt  = seg_start;
        length_nxt = seg_length;
      end else if (prev_after) begin
        start_nxt  = prev_start;
        length_nxt = prev_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    length_r <= length_nxt;
  end

  assign cur_start  = start_r;
  assign cur_length = length_r;

endmodule

### hw/rtl/srto_chain.sv
// Row of srto_cell slots plus the registered hit vector and the
// first-hit encoder used by overlap queries. Depends on srto_pkg.
module srto_chain (
  input  logic                        clk,
  input  srto_pkg::chain_ctrl_t       ctrl,
  input  logic [srto_pkg::CNT_W-1:0]  count,
  input  logic [srto_pkg::ADDR_W-1:0] seg_start,
  input  logic [srto_pkg::ADDR_W-1:0] seg_length,
  output srto_pkg::chain_stat_t       stat
);
  import srto_pkg::*;

  logic [SUM_W-1:0]       seg_end;
  logic [MAX_ENTRIES-1:0] after;
  logic [MAX_ENTRIES-1:0] hit;
  logic [MAX_ENTRIES-1:0] hit_r;
  logic [ADDR_W-1:0]      cell_start  [MAX_ENTRIES];
  logic [ADDR_W-1:0]      cell_length [MAX_ENTRIES];
  logic                   found;
  logic [IDX_W-1:0]       first_idx;

  assign seg_end = {1'b0, seg_start} + {1'b0, seg_length};

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic              occ;
    logic              prev_after;
    logic [ADDR_W-1:0] prev_start;
    logic [ADDR_W-1:0] prev_length;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign prev_after  = 1'b0;
      assign prev_start  = seg_start;
      assign prev_length = seg_length;
    end else begin : g_body
      assign prev_after  = after[i-1];
      assign prev_start  = cell_start[i-1];
      assign prev_length = cell_length[i-1];
    end

    srto_cell u_cell (
      .clk         (clk),
      .ins_en      (ctrl.do_insert),
      .occ         (occ),
      .seg_start   (seg_start),
      .seg_length  (seg_length),
      .seg_end     (seg_end),
      .prev_after  (prev_after),
      .prev_start  (prev_start),
      .prev_length (prev_length),
      .after       (after[i]),
      .hit         (hit[i]),
      .cur_start   (cell_start[i]),
      .cur_length  (cell_length[i])
    );
  end

  always_ff @(posedge clk) begin
    if (ctrl.do_query) begin
      hit_r <= hit;
    end
  end

  // lowest index wins
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        found     = 1'b1;
        first_idx = IDX_W'(i);
      end
    end
  end

  assign stat.found  = found;
  assign stat.idx    = first_idx;
  assign stat.start  = cell_start[first_idx];
  assign stat.length = cell_length[first_idx];

endmodule
